// File: hw/rtl/tmhpq_pkg.sv
// types and constants shared by the task min-heap priority queue unit
`timescale 1ns / 1ps

package tmhpq_pkg;

   localparam int KEY_W      = 32;
   localparam int TASK_W     = 8;
   localparam int COUNT_W    = 6;
   localparam int CSR_DATA_W = 8;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [1:0] KEY_BURST    = 2'd0;
   localparam logic [1:0] KEY_PRIORITY = 2'd1;
   localparam logic [1:0] KEY_ARRIVAL  = 2'd2;

   localparam logic CSR_CAPACITY   = 1'b0;
   localparam logic CSR_KEY_SELECT = 1'b1;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET   = 6'd32;
   localparam logic [1:0]         KEY_SELECT_RESET = KEY_PRIORITY;

   typedef struct packed {
      logic              opcode;
      logic [TASK_W-1:0] task_id;
      logic [KEY_W-1:0]  burst_time;
      logic [KEY_W-1:0]  priority_level;
      logic [KEY_W-1:0]  arrival_time;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               removed_valid;
      logic [TASK_W-1:0]  removed_task;
      logic [COUNT_W-1:0] count_after;
      logic               head_valid;
      logic [TASK_W-1:0]  head_task;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TASK_W-1:0] task_id;
   } entry_type;

   typedef struct packed {
      logic [COUNT_W-1:0] capacity_limit;
      logic [1:0]         key_select;
   } csr_type;

endpackage

// File: hw/rtl/tmhpq_heap_mem.sv
// heap entry memory, one write port and two registered read ports
`timescale 1ns / 1ps

module tmhpq_heap_mem
   import tmhpq_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic [AW-1:0]   rd_addr_a,
   input  logic [AW-1:0]   rd_addr_b,
   output entry_type       rd_data_a,
   output entry_type       rd_data_b
);

   entry_type mem [DEPTH];
   entry_type rd_data_a_ff;
   entry_type rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: hw/rtl/tmhpq_csr.sv
// configuration registers: capacity limit and key select
`timescale 1ns / 1ps

module tmhpq_csr
   import tmhpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output csr_type               csr_regs
);

   logic [COUNT_W-1:0] capacity_ff;
   logic [COUNT_W-1:0] capacity_in;
   logic [1:0]         key_select_ff;
   logic [1:0]         key_select_in;

   assign csr_ready = 1'b1;

   always_comb begin
      capacity_in   = capacity_ff;
      key_select_in = key_select_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CAPACITY:   capacity_in   = csr_data[COUNT_W-1:0];
            CSR_KEY_SELECT: key_select_in = csr_data[1:0];
            default:        capacity_in   = capacity_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAPACITY_RESET;
         key_select_ff <= KEY_SELECT_RESET;
      end else begin
         capacity_ff   <= capacity_in;
         key_select_ff <= key_select_in;
      end
   end

   assign csr_regs.capacity_limit = capacity_ff;
   assign csr_regs.key_select     = key_select_ff;

endmodule

// File: hw/rtl/task_min_heap_priority_queue_unit.sv
// top level: heap controller with sift-up and sift-down sequencer
// enqueue: idle, sift-up read/compare loop, response; dequeue: idle, last-entry fetch,
// sift-down read/compare loop, response; full, empty or last-entry requests skip the loops
// each heap level takes a memory read state and then a compare/write state
// one request at a time: busy until the strobe cycle ends
// synchronous reset empties the heap and sets capacity 32, key select priority
`timescale 1ns / 1ps

module task_min_heap_priority_queue_unit
   import tmhpq_pkg::*;
#(
   parameter int HEAP_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW   = $clog2(HEAP_DEPTH);
   localparam int CW   = $clog2(HEAP_DEPTH + 1);
   localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int CHW  = AW + 2;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_UP_READ = 7'b0000010,
      S_UP_CMP  = 7'b0000100,
      S_DN_LAST = 7'b0001000,
      S_DN_READ = 7'b0010000,
      S_DN_CMP  = 7'b0100000,
      S_RESP    = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     pos_ff, pos_in;
   entry_type         moving_ff, moving_in;
   logic [TASK_W-1:0] head_ff, head_in;
   logic [1:0]        status_ff, status_in;
   logic              removed_valid_ff, removed_valid_in;
   logic [TASK_W-1:0] removed_task_ff, removed_task_in;

   csr_type           csr_regs;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_data;
   logic [AW-1:0]     rd_addr_a;
   logic [AW-1:0]     rd_addr_b;
   entry_type         rd_data_a;
   entry_type         rd_data_b;

   logic              req_accept;
   logic [CMPW-1:0]   cap_eff;
   logic [KEY_W-1:0]  new_key;
   logic [AW-1:0]     parent;
   logic [CHW-1:0]    left_idx;
   logic [CHW-1:0]    right_idx;
   logic [CHW-1:0]    count_wide;
   logic              take_left;
   logic              take_right;
   logic [KEY_W-1:0]  best_key;

   tmhpq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_regs  (csr_regs)
   );

   tmhpq_heap_mem #(
      .DEPTH (HEAP_DEPTH),
      .AW    (AW)
   ) u_heap_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign busy       = (state_ff != S_IDLE);
   assign req_accept = start && !busy;

   always_comb begin
      if (CMPW'(csr_regs.capacity_limit) > CMPW'(HEAP_DEPTH)) begin
         cap_eff = CMPW'(HEAP_DEPTH);
      end else begin
         cap_eff = CMPW'(csr_regs.capacity_limit);
      end
   end

   always_comb begin
      case (csr_regs.key_select)
         KEY_BURST:    new_key = req_payload.burst_time;
         KEY_PRIORITY: new_key = req_payload.priority_level;
         default:      new_key = req_payload.arrival_time;
      endcase
   end

   assign parent     = (pos_ff - AW'(1)) >> 1;
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + CHW'(1);
   assign count_wide = CHW'(count_ff);

   assign take_left  = rd_data_a.key < moving_ff.key;
   assign best_key   = take_left ? rd_data_a.key : moving_ff.key;
   assign take_right = (right_idx < count_wide) && (rd_data_b.key < best_key);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      pos_in           = pos_ff;
      moving_in        = moving_ff;
      status_in        = status_ff;
      removed_valid_in = removed_valid_ff;
      removed_task_in  = removed_task_ff;
      wr_en            = 1'b0;
      wr_addr          = pos_ff;
      wr_data          = moving_ff;
      rd_addr_a        = parent;
      rd_addr_b        = right_idx[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in        = STATUS_OK;
               removed_valid_in = 1'b0;
               removed_task_in  = '0;
               if (req_payload.opcode == OP_ENQUEUE) begin
                  if (CMPW'(count_ff) >= cap_eff) begin
                     status_in = STATUS_FULL;
                     state_in  = S_RESP;
                  end else begin
                     moving_in.key     = new_key;
                     moving_in.task_id = req_payload.task_id;
                     pos_in            = count_ff[AW-1:0];
                     count_in          = count_ff + CW'(1);
                     state_in          = S_UP_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     removed_valid_in = 1'b1;
                     removed_task_in  = head_ff;
                     count_in         = count_ff - CW'(1);
                     rd_addr_a        = AW'(count_ff - CW'(1));
                     if (count_ff == CW'(1)) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_DN_LAST;
                     end
                  end
               end
            end
         end
         S_UP_READ: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (moving_ff.key < rd_data_a.key) begin
               wr_data  = rd_data_a;
               pos_in   = parent;
               state_in = S_UP_READ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_DN_LAST: begin
            moving_in = rd_data_a;
            pos_in    = '0;
            state_in  = S_DN_READ;
         end
         S_DN_READ: begin
            rd_addr_a = left_idx[AW-1:0];
            if (left_idx >= count_wide) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (take_right) begin
               wr_data  = rd_data_b;
               pos_in   = right_idx[AW-1:0];
               state_in = S_DN_READ;
            end else if (take_left) begin
               wr_data  = rd_data_a;
               pos_in   = left_idx[AW-1:0];
               state_in = S_DN_READ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in = head_ff;
      if (wr_en && (wr_addr == '0)) begin
         head_in = wr_data.task_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      moving_ff        <= moving_in;
      head_ff          <= head_in;
      status_ff        <= status_in;
      removed_valid_ff <= removed_valid_in;
      removed_task_ff  <= removed_task_in;
   end

   assign rsp_valid                 = (state_ff == S_RESP);
   assign rsp_payload.status        = status_ff;
   assign rsp_payload.removed_valid = removed_valid_ff;
   assign rsp_payload.removed_task  = removed_task_ff;
   assign rsp_payload.count_after   = COUNT_W'(count_ff);
   assign rsp_payload.head_valid    = (count_ff != '0);
   assign rsp_payload.head_task     = (count_ff != '0) ? head_ff : '0;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HEAP_DEPTH))
      else $error("entry count above heap depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy)
      else $error("request accepted but unit not busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("unit still busy after response strobe");

   a_dequeue_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_payload.opcode == OP_DEQUEUE) && (count_ff != '0))
      |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("dequeue did not decrement entry count");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status_ff == STATUS_FULL)) |-> (count_ff == $past(count_ff)))
      else $error("dropped enqueue changed entry count");

endmodule

// File: test/task_min_heap_priority_queue_unit_test.sv
// self-checking testbench for the task min-heap priority queue unit
`timescale 1ns / 1ps

module task_min_heap_priority_queue_unit_test;
   import tmhpq_pkg::*;

   localparam int DEPTH       = 32;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      req_type req;
      bit      drain_first;
   } backlog_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = CSR_CAPACITY;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   backlog_item_type request_backlog[$];
   backlog_item_type next_item;
   rsp_type     pending_outcomes[$];
   rsp_type     oldest_outcome;
   int unsigned sender_idle_pct = 0;
   int unsigned mismatch_count  = 0;
   int unsigned stall_cycles    = 0;
   logic        req_accepted;

   // shadow copy of the heap and its registers
   logic [TASK_W-1:0]  shadow_task[DEPTH];
   logic [KEY_W-1:0]   shadow_key[DEPTH];
   int unsigned        shadow_count      = 0;
   logic [COUNT_W-1:0] shadow_capacity   = CAPACITY_RESET;
   logic [1:0]         shadow_key_select = KEY_SELECT_RESET;

   task_min_heap_priority_queue_unit #(
      .HEAP_DEPTH(DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void swap_entries(int unsigned a, int unsigned b);
      logic [TASK_W-1:0] t;
      logic [KEY_W-1:0]  k;
      t = shadow_task[a];
      k = shadow_key[a];
      shadow_task[a] = shadow_task[b];
      shadow_key[a]  = shadow_key[b];
      shadow_task[b] = t;
      shadow_key[b]  = k;
   endfunction

   function automatic rsp_type heap_outcome(req_type rq);
      rsp_type          o;
      int unsigned      lim, pos, parent, best, l, r;
      logic [KEY_W-1:0] k;
      o = '0;
      o.status = STATUS_OK;
      lim = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
      if (rq.opcode == OP_ENQUEUE) begin
         if (shadow_count >= lim) begin
            o.status = STATUS_FULL;
         end else begin
            case (shadow_key_select)
               KEY_BURST: begin
                  k = rq.burst_time;
               end
               KEY_PRIORITY: begin
                  k = rq.priority_level;
               end
               default: begin
                  k = rq.arrival_time;
               end
            endcase
            pos = shadow_count;
            shadow_task[pos] = rq.task_id;
            shadow_key[pos]  = k;
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (shadow_key[pos] >= shadow_key[parent]) break;
               swap_entries(pos, parent);
               pos = parent;
            end
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            o.status = STATUS_EMPTY;
         end else begin
            o.removed_valid = 1'b1;
            o.removed_task  = shadow_task[0];
            shadow_count--;
            shadow_task[0] = shadow_task[shadow_count];
            shadow_key[0]  = shadow_key[shadow_count];
            pos = 0;
            forever begin
               best = pos;
               l = 2 * pos + 1;
               r = 2 * pos + 2;
               if (l < shadow_count && shadow_key[l] < shadow_key[best]) best = l;
               if (r < shadow_count && shadow_key[r] < shadow_key[best]) best = r;
               if (best == pos) break;
               swap_entries(pos, best);
               pos = best;
            end
         end
      end
      o.count_after = COUNT_W'(shadow_count);
      o.head_valid  = (shadow_count != 0);
      o.head_task   = (shadow_count != 0) ? shadow_task[0] : '0;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         req_accepted = start && !busy;
         if (req_accepted) begin
            pending_outcomes.push_back(heap_outcome(req_payload));
         end
         if (!start || req_accepted) begin
            if (request_backlog.size() != 0
                && !(request_backlog[0].drain_first && pending_outcomes.size() != 0)
                && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_item = request_backlog.pop_front();
               req_payload <= next_item.req;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with no request pending", 32'(rsp_payload), 0);
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            if (rsp_payload.status !== oldest_outcome.status)
               report_mismatch("status", 32'(rsp_payload.status),
                               32'(oldest_outcome.status));
            if (rsp_payload.removed_valid !== oldest_outcome.removed_valid)
               report_mismatch("removed_valid", 32'(rsp_payload.removed_valid),
                               32'(oldest_outcome.removed_valid));
            if (rsp_payload.removed_task !== oldest_outcome.removed_task)
               report_mismatch("removed_task", 32'(rsp_payload.removed_task),
                               32'(oldest_outcome.removed_task));
            if (rsp_payload.count_after !== oldest_outcome.count_after)
               report_mismatch("count_after", 32'(rsp_payload.count_after),
                               32'(oldest_outcome.count_after));
            if (rsp_payload.head_valid !== oldest_outcome.head_valid)
               report_mismatch("head_valid", 32'(rsp_payload.head_valid),
                               32'(oldest_outcome.head_valid));
            if (rsp_payload.head_task !== oldest_outcome.head_task)
               report_mismatch("head_task", 32'(rsp_payload.head_task),
                               32'(oldest_outcome.head_task));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic add_request(logic op, logic [TASK_W-1:0] tid, logic [KEY_W-1:0] burst,
                              logic [KEY_W-1:0] prio, logic [KEY_W-1:0] arrival);
      backlog_item_type it;
      it.req.opcode         = op;
      it.req.task_id        = tid;
      it.req.burst_time     = burst;
      it.req.priority_level = prio;
      it.req.arrival_time   = arrival;
      it.drain_first        = 1'b0;
      request_backlog.push_back(it);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4, 5: return KEY_W'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   // bursts of mostly enqueues or mostly dequeues so the heap fills and drains
   task automatic add_random_requests(int unsigned n);
      backlog_item_type it;
      int unsigned run_left, enq_pct;
      run_left = 0;
      enq_pct  = 50;
      repeat (n) begin
         if (run_left == 0) begin
            run_left = $urandom_range(8, 40);
            enq_pct  = ($urandom_range(0, 1) != 0) ? 80 : 25;
         end
         run_left--;
         it.req.opcode         = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
         it.req.task_id        = TASK_W'($urandom());
         it.req.burst_time     = pick_key();
         it.req.priority_level = pick_key();
         it.req.arrival_time   = pick_key();
         it.drain_first        = ($urandom_range(0, 99) < 5);
         request_backlog.push_back(it);
      end
   endtask

   task automatic wait_for_quiet();
      while (request_backlog.size() != 0 || start || pending_outcomes.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_CAPACITY) shadow_capacity = value[COUNT_W-1:0];
      else shadow_key_select = value[1:0];
   endtask

   initial begin
      int unsigned idle_table[3] = '{12, 59, 0};
      int unsigned cap_table[12] = '{32, 63, 1, 0, 8, 40, 2, 0, 32, 17, 5, 63};
      int unsigned sel_table[12] = '{0, 2, 3, 0, 1, 0, 2, 0, 3, 1, 2, 0};
      int unsigned cap, sel, p;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: capacity 32, priority key
      add_request(OP_DEQUEUE, 8'h00, '0, '0, '0);
      add_request(OP_ENQUEUE, 8'h00, '0, '1, '0);
      add_request(OP_ENQUEUE, 8'hFF, '1, '0, '1);
      add_request(OP_ENQUEUE, 8'h5A, 32'h1, '0, 32'h2);
      add_request(OP_ENQUEUE, 8'hA5, 32'h3, 32'h7, 32'h4);
      add_request(OP_ENQUEUE, 8'h3C, 32'h5, 32'h7, 32'h6);
      add_request(OP_ENQUEUE, 8'hC3, 32'h8, 32'h8000_0000, 32'h9);
      repeat (7) add_request(OP_DEQUEUE, 8'hFF, '1, '1, '1);
      wait_for_quiet();

      // zero capacity: every enqueue is full
      write_csr(CSR_CAPACITY, 8'hC0);
      add_request(OP_ENQUEUE, 8'h12, 32'h1, 32'h1, 32'h1);
      add_request(OP_DEQUEUE, 8'h00, '0, '0, '0);
      wait_for_quiet();

      // key select three acts as arrival time
      write_csr(CSR_CAPACITY, 8'h82);
      write_csr(CSR_KEY_SELECT, 8'hFF);
      add_request(OP_ENQUEUE, 8'h11, 32'h9, 32'h1, 32'h5);
      add_request(OP_ENQUEUE, 8'h22, 32'h1, 32'h9, 32'h3);
      add_request(OP_ENQUEUE, 8'h33, 32'h0, 32'h0, 32'h0);
      wait_for_quiet();

      // capacity below the current count
      write_csr(CSR_CAPACITY, 8'h41);
      add_request(OP_ENQUEUE, 8'h44, 32'h0, 32'h0, 32'h0);
      add_request(OP_DEQUEUE, 8'h00, '0, '0, '0);
      add_request(OP_DEQUEUE, 8'h00, '0, '0, '0);

      for (int r = 0; r < 3; r++) begin
         for (int ph = 0; ph < 4; ph++) begin
            wait_for_quiet();
            sender_idle_pct = idle_table[r];
            p = r * 4 + ph;
            cap = cap_table[p];
            sel = sel_table[p];
            if (ph == 3) begin
               cap = $urandom_range(0, 63);
               sel = $urandom_range(0, 3);
            end
            write_csr(CSR_CAPACITY, {2'($urandom_range(0, 3)), 6'(cap)});
            write_csr(CSR_KEY_SELECT, {6'($urandom_range(0, 63)), 2'(sel)});
            add_random_requests(60);
         end
      end

      wait_for_quiet();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
